/* src/assert_macros.svh */
// Assertion macros shared by the tracker RTL.
// Plain text only; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/dtt_pkg.sv */
// Shared types, constants and helpers for the distinct draw tracker.
// No dependencies; used by dtt_cfg_regs, dtt_trial and distinct_draw_tracker.
`default_nettype none

package dtt_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = 9;
    localparam int DRAW_W    = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ITEM_COUNT = 1'b0;
    localparam logic REG_DRAW_LIMIT = 1'b1;

    localparam logic [CNT_W-1:0]  ITEM_COUNT_RST = CNT_W'(256);
    localparam logic [DRAW_W-1:0] DRAW_LIMIT_RST = DRAW_W'(5120);

    typedef struct packed {
        logic [CNT_W-1:0]  item_count;
        logic [DRAW_W-1:0] draw_limit;
    } cfg_t;

    typedef struct packed {
        logic              emit;
        logic [DRAW_W-1:0] total_draws;
        logic [CNT_W-1:0]  items_found;
        logic              trial_failed;
    } trial_res_t;

    // item_count clamped to the bitmap size
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] item_count);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(MAX_ITEMS);
        return (item_count > lim) ? lim : item_count;
    endfunction

endpackage

`default_nettype wire

/* src/dtt_cfg_regs.sv */
// APB-style configuration registers: item_count and draw_limit.
// Depends on dtt_pkg.
`default_nettype none

module dtt_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dtt_pkg::APB_AW-1:0]  paddr,
    input  wire logic [dtt_pkg::APB_DW-1:0]  pwdata,
    output logic      [dtt_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output dtt_pkg::cfg_t                    cfg
);

    dtt_pkg::cfg_t cfg_reg;
    dtt_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                dtt_pkg::REG_ITEM_COUNT: cfg_next.item_count = pwdata[dtt_pkg::CNT_W-1:0];
                dtt_pkg::REG_DRAW_LIMIT: cfg_next.draw_limit = pwdata[dtt_pkg::DRAW_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.item_count <= dtt_pkg::ITEM_COUNT_RST;
            cfg_reg.draw_limit <= dtt_pkg::DRAW_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            dtt_pkg::REG_ITEM_COUNT:
                prdata = {{(dtt_pkg::APB_DW-dtt_pkg::CNT_W){1'b0}}, cfg_reg.item_count};
            dtt_pkg::REG_DRAW_LIMIT:
                prdata = {{(dtt_pkg::APB_DW-dtt_pkg::DRAW_W){1'b0}}, cfg_reg.draw_limit};
            default: prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/dtt_trial.sv */
// Trial state: seen bitmap, distinct count and draw count, with end-of-trial check.
// Depends on dtt_pkg. Result is combinational from state and the staged draw.
`default_nettype none

module dtt_trial (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  dtt_pkg::cfg_t                    cfg,
    input  wire logic                        step,
    input  wire logic [dtt_pkg::IDX_W-1:0]   idx,
    output dtt_pkg::trial_res_t              res
);

    logic [dtt_pkg::MAX_ITEMS-1:0] seen_reg;
    logic [dtt_pkg::MAX_ITEMS-1:0] seen_next;
    logic [dtt_pkg::CNT_W-1:0]     found_reg;
    logic [dtt_pkg::CNT_W-1:0]     found_next;
    logic [dtt_pkg::DRAW_W-1:0]    draws_reg;
    logic [dtt_pkg::DRAW_W-1:0]    draws_next;

    logic [dtt_pkg::CNT_W-1:0]     eff;
    logic                          in_range;
    logic [dtt_pkg::CNT_W-1:0]     found_upd;
    logic [dtt_pkg::DRAW_W-1:0]    draws_upd;
    logic                          done;
    logic                          failed;

    always_comb
    begin
        eff       = dtt_pkg::eff_count(cfg.item_count);
        in_range  = {{(dtt_pkg::CNT_W-dtt_pkg::IDX_W){1'b0}}, idx} < eff;
        found_upd = seen_reg[idx] ? found_reg : found_reg + 1'b1;
        draws_upd = draws_reg + 1'b1;
        done      = found_upd >= eff;
        failed    = !done && (draws_upd >= cfg.draw_limit);

        res.emit         = in_range && (done || failed);
        res.total_draws  = draws_upd;
        res.items_found  = found_upd;
        res.trial_failed = failed;

        seen_next  = seen_reg;
        found_next = found_reg;
        draws_next = draws_reg;
        if (step && in_range)
        begin
            if (done || failed)
            begin
                // trial over: start the next one clean
                seen_next  = '0;
                found_next = '0;
                draws_next = '0;
            end
            else
            begin
                seen_next[idx] = 1'b1;
                found_next     = found_upd;
                draws_next     = draws_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            found_reg <= '0;
            draws_reg <= '0;
        end
        else
        begin
            seen_reg  <= seen_next;
            found_reg <= found_next;
            draws_reg <= draws_next;
        end
    end

endmodule

`default_nettype wire

/* src/distinct_draw_tracker.sv */
// Top level of the distinct draw tracker: input stage, trial core, result register.
// Depends on dtt_pkg, dtt_cfg_regs, dtt_trial and assert_macros.svh.
`default_nettype none

// Coupon-collector tracker. Each input beat carries one draw index; indices
// at or above item_count (clamped to 256) are dropped silently and do not
// count as draws. A trial ends when every item has been seen or the draw
// count reaches draw_limit; one result beat then reports the draws taken,
// the distinct items found and a failure flag, and the next trial starts
// clean. Finding the last item on the limiting draw counts as success.
// Rate: one draw per cycle. A beat is registered on acceptance and checked
// against the flop bitmap and counters when it advances out of the input
// stage; any result it closes is loaded into the output register as it
// advances, and that register drives out_valid. The input stage stalls only
// while a staged beat waits behind a result that sits unclaimed with
// out_ready low. Registers: item_count at address 0, draw_limit at address 4
// (decoded on paddr[2]); program them only while no beat is in flight.

`include "assert_macros.svh"

module distinct_draw_tracker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dtt_pkg::APB_AW-1:0]  paddr,
    input  wire logic [dtt_pkg::APB_DW-1:0]  pwdata,
    output logic      [dtt_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  draw_index,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [15:0]                 total_draws,
    output logic      [8:0]                  items_found,
    output logic                             trial_failed
);

    dtt_pkg::cfg_t       cfg;
    dtt_pkg::trial_res_t res;

    // input stage
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [dtt_pkg::IDX_W-1:0]   idx_reg;

    // result register
    logic                        res_valid_reg;
    logic                        res_valid_next;
    logic [dtt_pkg::DRAW_W-1:0]  total_reg;
    logic [dtt_pkg::CNT_W-1:0]   found_reg;
    logic                        failed_reg;

    logic                        advance;
    logic                        load_res;

    dtt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dtt_trial u_trial (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .idx   (idx_reg),
        .res   (res)
    );

    // staged beat moves on whenever the result slot is free or draining
    assign advance  = s1_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign load_res = advance && res.emit;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (advance)
            s1_valid_next = 1'b0;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;

        res_valid_next = res_valid_reg;
        if (res_valid_reg && out_ready)
            res_valid_next = 1'b0;
        if (load_res)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            idx_reg <= draw_index;
        if (load_res)
        begin
            total_reg  <= res.total_draws;
            found_reg  <= res.items_found;
            failed_reg <= res.trial_failed;
        end
    end

    assign out_valid    = res_valid_reg;
    assign total_draws  = total_reg;
    assign items_found  = found_reg;
    assign trial_failed = failed_reg;

    // a result always covers at least one draw
    `ASSERT_CLK(a_draws_nonzero, clk, rst_n,
        out_valid |-> (total_draws != '0), "result with zero draws")

    // a completed trial reached the clamped item count; a count carried over
    // from a larger item_count may already sit above it
    `ASSERT_CLK(a_complete_count, clk, rst_n,
        (out_valid && !trial_failed) |->
            (items_found >= dtt_pkg::eff_count(cfg.item_count)),
        "completed trial short of the item count")

    // distinct items can never exceed draws
    `ASSERT_CLK(a_found_le_draws, clk, rst_n,
        out_valid |-> ({7'b0, items_found} <= total_draws), "found exceeds draws")

    // input stalls only behind a held beat that cannot move
    `ASSERT_ALWAYS(a_stall_cause,
        clk, !in_ready |-> (s1_valid_reg && res_valid_reg && !out_ready),
        "input stalled without cause")

endmodule

`default_nettype wire
